### rtl/mpsm_pkg.sv
// mpsm_pkg: shared types and codes for the multi-pattern string matcher.
// No dependencies.
package mpsm_pkg;

    localparam int MODE_W  = 2;
    localparam int SYM_W   = 8;
    localparam int MASK_W  = 32;
    localparam int STATE_W = 9;
    localparam int STAT_W  = 3;
    localparam int POS_W   = 32;

    // item kinds
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KEY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BUILD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd3;

    // result status
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_WORDS     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOT_BUILT = 3'd4;

    // config register indexes
    localparam logic CFG_LOWEST = 1'b0;
    localparam logic CFG_ASIZE  = 1'b1;

    typedef struct packed {
        logic [MASK_W-1:0]  match_mask;
        logic [STATE_W-1:0] current_state;
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   text_position;
    } t_result;

endpackage

### rtl/mpsm_in_if.sv
// mpsm_in_if: input item channel (valid/ready plus item fields).
// Depends on mpsm_pkg.
interface mpsm_in_if;
    logic                       valid;
    logic                       ready;
    logic [mpsm_pkg::MODE_W-1:0] mode;
    logic [mpsm_pkg::SYM_W-1:0]  symbol;
    logic                       last_of_word;

    modport source (output valid, mode, symbol, last_of_word, input ready);
    modport sink   (input valid, mode, symbol, last_of_word, output ready);
endinterface

### rtl/mpsm_out_if.sv
// mpsm_out_if: result item channel (valid/ready plus result fields).
// Depends on mpsm_pkg.
interface mpsm_out_if;
    logic                         valid;
    logic                         ready;
    logic [mpsm_pkg::MASK_W-1:0]  match_mask;
    logic [mpsm_pkg::STATE_W-1:0] current_state;
    logic [mpsm_pkg::STAT_W-1:0]  status;
    logic [mpsm_pkg::POS_W-1:0]   text_position;

    modport source (output valid, match_mask, current_state, status, text_position,
                    input ready);
    modport sink   (input valid, match_mask, current_state, status, text_position,
                    output ready);
endinterface

### rtl/mpsm_ram.sv
// mpsm_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/multi_pattern_string_matcher.sv
// multi_pattern_string_matcher: Aho-Corasick dictionary matcher, top level.
// Depends on mpsm_pkg, mpsm_in_if, mpsm_out_if, mpsm_ram.
// Clear and refused items go straight to the result. A keyword char reads the goto RAM and may add a
// node; a word end then also sets its mask bit. Text follows failure hops; build walks breadth first.
// One item in flight; the next is accepted once idle again after its result loads; output stalls add.
// Reset and clear: sweep over all MAX_STATES*ALPHABET goto RAM entries, also clearing the mask RAM.
module multi_pattern_string_matcher #(
    parameter int MAX_STATES = 512,
    parameter int ALPHABET   = 32,
    parameter int MAX_WORDS  = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mpsm_in_if.sink        i_in,
    mpsm_out_if.source     o_out,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [7:0]     i_cfg_data
);
    localparam int SW    = $clog2(MAX_STATES);      // node index
    localparam int CW    = $clog2(ALPHABET);        // symbol index
    localparam int GD    = MAX_STATES * ALPHABET;   // goto entries
    localparam int GW    = $clog2(GD);
    localparam int WCW   = $clog2(MAX_WORDS + 1);
    localparam int MW    = mpsm_pkg::MASK_W;

    localparam logic [4:0] S_SWEEP    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_KW_RD    = 5'd2;
    localparam logic [4:0] S_KW_MK    = 5'd3;
    localparam logic [4:0] S_TX_G     = 5'd4;
    localparam logic [4:0] S_TX_F     = 5'd5;
    localparam logic [4:0] S_TX_M     = 5'd6;
    localparam logic [4:0] S_B_EDGE   = 5'd7;
    localparam logic [4:0] S_B_WALK   = 5'd8;
    localparam logic [4:0] S_B_WALK_F = 5'd9;
    localparam logic [4:0] S_B_M1     = 5'd10;
    localparam logic [4:0] S_B_M2     = 5'd11;
    localparam logic [4:0] S_B_DEQ    = 5'd12;
    localparam logic [4:0] S_B_DEQF   = 5'd13;
    localparam logic [4:0] S_EMIT     = 5'd14;

    // goto RAM address: row per node, one entry per symbol
    function automatic logic [GW-1:0] gaddr(input logic [SW-1:0] node,
                                            input logic [CW-1:0] c);
        return GW'(GW'(node) * GW'(ALPHABET) + GW'(c));
    endfunction

    // control state
    logic [4:0]    r_state, n_state;
    logic [7:0]    r_lowest;
    logic [5:0]    r_asize;
    logic [SW:0]   r_ncnt, n_ncnt;
    logic [WCW-1:0] r_wcnt, n_wcnt;
    logic [SW-1:0] r_ins, n_ins;
    logic [SW-1:0] r_scan, n_scan;
    logic          r_built, n_built;
    logic [31:0]   r_pc, n_pc;
    logic [GW-1:0] r_sw, n_sw;
    logic          r_clr, n_clr;
    logic [SW:0]   r_head, n_head;
    logic [SW:0]   r_tail, n_tail;
    logic          r_ov, n_ov;
    // working registers
    logic [CW-1:0] r_c, n_c;
    logic          r_last, n_last;
    logic          r_root, n_root;
    logic [SW-1:0] r_node, n_node;
    logic [SW-1:0] r_s, n_s;
    logic [SW-1:0] r_fs, n_fs;
    logic [SW-1:0] r_ch, n_ch;
    logic [SW-1:0] r_t, n_t;
    logic [MW-1:0] r_mt, n_mt;
    logic          r_qf, n_qf;
    mpsm_pkg::t_result r_res, n_res;
    mpsm_pkg::t_result r_out, n_out;

    // RAM ports
    logic          g_we, f_we, m_we, q_we;
    logic [GW-1:0] g_waddr, g_raddr;
    logic [SW-1:0] g_wdata, g_rdata;
    logic [SW-1:0] f_waddr, f_raddr, f_wdata, f_rdata;
    logic [SW-1:0] m_waddr, m_raddr;
    logic [MW-1:0] m_wdata, m_rdata;
    logic [SW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

    mpsm_ram #(.WIDTH(SW), .DEPTH(GD)) u_goto (
        .i_clk, .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(g_rdata));
    mpsm_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_fail (
        .i_clk, .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata));
    mpsm_ram #(.WIDTH(MW), .DEPTH(MAX_STATES)) u_mask (
        .i_clk, .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata));
    mpsm_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_queue (
        .i_clk, .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata));

    // symbol decode
    logic [7:0] c_raw;
    logic [8:0] eff;
    logic       in_rng;
    logic       accept;
    logic       adv;
    logic [SW-1:0] nx;

    assign c_raw  = i_in.symbol - r_lowest;
    assign eff    = ({3'b0, r_asize} < 9'(ALPHABET)) ? {3'b0, r_asize} : 9'(ALPHABET);
    assign in_rng = {1'b0, c_raw} < eff;
    assign accept = i_in.valid && i_in.ready;

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ov;
    assign o_out.match_mask    = r_out.match_mask;
    assign o_out.current_state = r_out.current_state;
    assign o_out.status        = r_out.status;
    assign o_out.text_position = r_out.text_position;

    always_comb begin
        n_state = r_state; n_ncnt = r_ncnt; n_wcnt = r_wcnt; n_ins = r_ins;
        n_scan = r_scan; n_built = r_built; n_pc = r_pc; n_sw = r_sw; n_clr = r_clr;
        n_head = r_head; n_tail = r_tail; n_ov = r_ov; n_c = r_c; n_last = r_last;
        n_root = r_root; n_node = r_node; n_s = r_s; n_fs = r_fs; n_ch = r_ch;
        n_t = r_t; n_mt = r_mt; n_qf = r_qf; n_res = r_res; n_out = r_out;
        g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
        adv = 1'b0;
        nx  = g_rdata;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_SWEEP: begin
                g_we    = 1'b1;
                g_waddr = r_sw;
                m_we    = (32'(r_sw) < 32'(MAX_STATES));
                m_waddr = SW'(r_sw);
                n_sw    = r_sw + GW'(1);
                if (32'(r_sw) == GD - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_c    = CW'(c_raw);
                    n_last = i_in.last_of_word;
                    n_res  = '0;
                    n_res.text_position = r_pc;
                    n_state = S_EMIT;
                    case (i_in.mode)
                        mpsm_pkg::MODE_CLEAR: begin
                            n_ncnt = (SW+1)'(1); n_wcnt = '0; n_ins = '0; n_scan = '0;
                            n_built = 1'b0; n_pc = '0; n_clr = 1'b1;
                            n_res.text_position = '0;
                        end
                        mpsm_pkg::MODE_KEY: begin
                            n_res.current_state = 9'(r_ins);
                            if (!in_rng) begin
                                n_res.status = mpsm_pkg::STAT_RANGE;
                            end else if (32'(r_wcnt) >= MAX_WORDS) begin
                                n_res.status = mpsm_pkg::STAT_WORDS;
                            end else begin
                                g_raddr = gaddr(r_ins, CW'(c_raw));
                                n_state = S_KW_RD;
                            end
                        end
                        mpsm_pkg::MODE_BUILD: begin
                            n_s = '0; n_fs = '0; n_root = 1'b1; n_c = '0;
                            n_head = '0; n_tail = '0;
                            g_raddr = gaddr('0, '0);
                            n_state = S_B_EDGE;
                        end
                        default: begin
                            n_res.current_state = 9'(r_scan);
                            if (!r_built) begin
                                n_res.status = mpsm_pkg::STAT_NOT_BUILT;
                            end else if (!in_rng) begin
                                n_res.status = mpsm_pkg::STAT_RANGE;
                            end else begin
                                n_node  = r_scan;
                                g_raddr = gaddr(r_scan, CW'(c_raw));
                                n_state = S_TX_G;
                            end
                        end
                    endcase
                end
            end
            S_KW_RD: begin
                if (g_rdata == '0 && 32'(r_ncnt) >= MAX_STATES) begin
                    n_res.status = mpsm_pkg::STAT_FULL;
                    n_state = S_EMIT;
                end else begin
                    if (g_rdata == '0) begin
                        nx      = SW'(r_ncnt);
                        g_we    = 1'b1;
                        g_waddr = gaddr(r_ins, r_c);
                        g_wdata = nx;
                        n_ncnt  = r_ncnt + (SW+1)'(1);
                    end
                    n_built = 1'b0;
                    n_res.current_state = 9'(nx);
                    if (r_last) begin
                        n_ch    = nx;
                        m_raddr = nx;
                        n_state = S_KW_MK;
                    end else begin
                        n_ins   = nx;
                        n_state = S_EMIT;
                    end
                end
            end
            S_KW_MK: begin
                m_we    = 1'b1;
                m_waddr = r_ch;
                m_wdata = m_rdata | (MW'(1) << r_wcnt);
                n_wcnt  = r_wcnt + WCW'(1);
                n_ins   = '0;
                n_state = S_EMIT;
            end
            // failure walk for a text character
            S_TX_G: begin
                if (r_node != '0 && g_rdata == '0) begin
                    f_raddr = r_node;
                    n_state = S_TX_F;
                end else begin
                    n_scan  = g_rdata;
                    m_raddr = g_rdata;
                    n_state = S_TX_M;
                end
            end
            S_TX_F: begin
                n_node  = f_rdata;
                g_raddr = gaddr(f_rdata, r_c);
                n_state = S_TX_G;
            end
            S_TX_M: begin
                n_res.match_mask    = m_rdata;
                n_res.current_state = 9'(r_scan);
                n_res.status        = mpsm_pkg::STAT_OK;
                n_res.text_position = r_pc;
                n_pc    = r_pc + 32'd1;
                n_state = S_EMIT;
            end
            // build: child of r_s on symbol r_c is in g_rdata
            S_B_EDGE: begin
                if (g_rdata != '0 && 32'(r_tail) < MAX_STATES) begin
                    n_ch = g_rdata;
                    if (r_root) begin
                        n_t     = '0;
                        m_raddr = '0;
                        n_state = S_B_M1;
                    end else begin
                        n_node  = r_fs;
                        g_raddr = gaddr(r_fs, r_c);
                        n_state = S_B_WALK;
                    end
                end else begin
                    adv = 1'b1;
                end
            end
            S_B_WALK: begin
                if (r_node != '0 && g_rdata == '0) begin
                    f_raddr = r_node;
                    n_state = S_B_WALK_F;
                end else begin
                    n_t     = g_rdata;
                    m_raddr = g_rdata;
                    n_state = S_B_M1;
                end
            end
            S_B_WALK_F: begin
                n_node  = f_rdata;
                g_raddr = gaddr(f_rdata, r_c);
                n_state = S_B_WALK;
            end
            S_B_M1: begin
                n_mt    = m_rdata;
                m_raddr = r_ch;
                n_state = S_B_M2;
            end
            S_B_M2: begin
                m_we    = 1'b1; m_waddr = r_ch; m_wdata = m_rdata | r_mt;
                f_we    = 1'b1; f_waddr = r_ch; f_wdata = r_t;
                q_we    = 1'b1; q_waddr = SW'(r_tail); q_wdata = r_ch;
                n_tail  = r_tail + (SW+1)'(1);
                adv     = 1'b1;
            end
            S_B_DEQ: begin
                // forwarded entry when it was queued on the same edge as its read
                n_s     = r_qf ? r_s : q_rdata;
                n_root  = 1'b0;
                f_raddr = r_qf ? r_s : q_rdata;
                n_state = S_B_DEQF;
            end
            S_B_DEQF: begin
                n_fs    = f_rdata;
                n_c     = '0;
                g_raddr = gaddr(r_s, '0);
                n_state = S_B_EDGE;
            end
            S_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_sw    = '0;
                    n_clr   = 1'b0;
                    n_state = r_clr ? S_SWEEP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // next symbol, next queued node, or build done
        if (adv) begin
            if (32'(r_c) != ALPHABET - 1) begin
                n_c     = r_c + CW'(1);
                g_raddr = gaddr(r_s, r_c + CW'(1));
                n_state = S_B_EDGE;
            end else if (r_head < n_tail) begin
                q_raddr = SW'(r_head);
                n_head  = r_head + (SW+1)'(1);
                // queue write and read of one entry on one edge: RAM gives old data
                n_qf    = q_we && (q_waddr == SW'(r_head));
                n_s     = r_ch;
                n_state = S_B_DEQ;
            end else begin
                n_built = 1'b1;
                n_scan  = '0;
                n_pc    = '0;
                n_res   = '0;
                n_state = S_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_lowest <= 8'd97;
            r_asize  <= 6'd26;
            r_ncnt   <= (SW+1)'(1);
            r_wcnt   <= '0;
            r_ins    <= '0;
            r_scan   <= '0;
            r_built  <= 1'b0;
            r_pc     <= '0;
            r_sw     <= '0;
            r_clr    <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ncnt  <= n_ncnt;
            r_wcnt  <= n_wcnt;
            r_ins   <= n_ins;
            r_scan  <= n_scan;
            r_built <= n_built;
            r_pc    <= n_pc;
            r_sw    <= n_sw;
            r_clr   <= n_clr;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                if (i_cfg_idx == mpsm_pkg::CFG_LOWEST) begin
                    r_lowest <= i_cfg_data;
                end else begin
                    r_asize <= i_cfg_data[5:0];
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_c    <= n_c;
        r_last <= n_last;
        r_root <= n_root;
        r_node <= n_node;
        r_s    <= n_s;
        r_fs   <= n_fs;
        r_ch   <= n_ch;
        r_t    <= n_t;
        r_mt   <= n_mt;
        r_qf   <= n_qf;
        r_res  <= n_res;
        r_out  <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_node_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ncnt) <= MAX_STATES && 32'(r_wcnt) <= MAX_WORDS)
        else $error("node or word count beyond limit");
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("build queue head passed tail");
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TX_M) |=> (r_pc == $past(r_pc) + 32'd1))
        else $error("text position did not advance");
`endif

endmodule
